// ===== hdl/ucrw_pkg.sv =====
`default_nettype none
package ucrw_pkg;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNALIGNED  = 2'd1;
  localparam logic [1:0] ST_UNMODELLED = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  localparam logic [6:0] CW_CMD  = 7'h50;
  localparam logic [6:0] CW_STS  = 7'h51;
  localparam logic [6:0] CW_VIEW = 7'h5C;

  localparam logic [31:0] STS_RO   = 32'h0000_F000;
  localparam logic [31:0] STS_HALT = 32'h0000_1000;
  localparam logic [31:0] STS_PSS  = 32'h0000_4000;
  localparam logic [31:0] STS_ASS  = 32'h0000_8000;

  typedef struct packed {
    logic        op;
    logic [13:0] addr;
    logic [1:0]  size;
    logic [31:0] data;
    logic [1:0]  err;
  } entry_t;

  function automatic logic offset_known(input logic [13:0] off, input int num_cores);
    logic [6:0] cw;
    logic       res;
    cw = off[8:2];
    if (off[13:11] != 3'd0) begin
      res = (off[13:6] == 8'h20);
    end else if ({30'd0, off[10:9]} >= num_cores) begin
      res = 1'b0;
    end else if (cw >= 7'h50 && cw <= 7'h59) begin
      res = 1'b1;
    end else if (cw >= 7'h6B && cw <= 7'h77) begin
      res = 1'b1;
    end else begin
      res = (cw == 7'h40) || (cw == 7'h41) || (cw == 7'h42) || (cw == 7'h48) ||
            (cw == 7'h49) || (cw == 7'h5C) || (cw == 7'h60) || (cw == 7'h61) ||
            (cw == 7'h69) || (cw == 7'h6A);
    end
    return res;
  endfunction

  function automatic logic [31:0] reg_reset(input logic [11:0] w, input int num_cores);
    logic [31:0] v;
    v = 32'd0;
    if (w[11:9] == 3'd0 && {30'd0, w[8:7]} < num_cores) begin
      unique case (w[6:0])
        7'h40:   v = 32'h0100_0040;
        7'h41:   v = 32'h0000_0001;
        7'h42:   v = 32'h0000_0006;
        7'h48:   v = 32'h0000_0001;
        7'h49:   v = 32'h0000_0002;
        7'h51:   v = STS_HALT;
        7'h61:   v = 32'h0000_1000;
        default: v = 32'd0;
      endcase
    end
    return v;
  endfunction

  function automatic logic [7:0] phy_reset(input logic [5:0] a);
    logic [7:0] v;
    unique case (a)
      6'd0:    v = 8'h24;
      6'd1:    v = 8'h04;
      6'd2:    v = 8'h06;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/usb_controller_register_window.sv =====
`default_nettype none
// Register window of a multi-core USB host controller with a PHY viewport.
// Command channel: an access (operation, address, access_size, write_data)
// is taken at a rising edge with start high and busy low.
// Result channel: done is high for one cycle with read_data and status;
// the receiver cannot stall, results are never held.
// Accesses pass a two-entry queue into a back end that owns the register
// memory (4096 words, one write and one registered read port) and the
// 64-byte PHY store.
// An access with an error is answered from the idle state; plain reads and
// writes pass S_DATA, command writes (status update) and viewport PHY reads
// pass S_DATA and then S_STS or S_PHY; the back end takes one access at a time.
// Reset: a sweep over all 4096 words loads the reset values into both stores;
// busy stays high until the sweep ends.
module usb_controller_register_window #(
  parameter int NUM_CORES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [13:0] address,
  input  wire logic [1:0]  access_size,
  input  wire logic [31:0] write_data,
  output logic             done,
  output logic [31:0]      read_data,
  output logic [1:0]       status
);

  ucrw_pkg::entry_t head;
  logic             empty;
  logic             full;
  logic             pop;
  logic             ready;
  logic             push;

  assign busy = full || !ready;
  assign push = start && !busy;

  ucrw_front #(.NUM_CORES(NUM_CORES)) u_front (
    .clk, .rst, .push, .operation, .address, .access_size, .write_data,
    .pop, .head, .empty, .full
  );

  ucrw_back #(.NUM_CORES(NUM_CORES)) u_back (
    .clk, .rst, .head, .empty, .pop, .ready, .done, .read_data, .status
  );

endmodule
`default_nettype wire

// ===== hdl/ucrw_front.sv =====
`default_nettype none
module ucrw_front #(
  parameter int NUM_CORES = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic            operation,
  input  wire logic [13:0]     address,
  input  wire logic [1:0]      access_size,
  input  wire logic [31:0]     write_data,
  input  wire logic            pop,
  output ucrw_pkg::entry_t     head,
  output logic                 empty,
  output logic                 full
);

  ucrw_pkg::entry_t q [2];
  ucrw_pkg::entry_t e;
  logic             wp;
  logic             rp;
  logic [1:0]       count;

  always_comb begin
    e.op   = operation;
    e.addr = address;
    e.size = access_size;
    e.data = write_data;
    if (access_size[1] && address[1:0] != 2'd0) begin
      e.err = ucrw_pkg::ST_UNALIGNED;
    end else if (!ucrw_pkg::offset_known({address[13:2], 2'b00}, NUM_CORES)) begin
      e.err = ucrw_pkg::ST_UNMODELLED;
    end else begin
      e.err = ucrw_pkg::ST_OK;
    end
  end

  assign head  = q[rp];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        q[wp] <= e;
        wp    <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");
  a_count: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== hdl/ucrw_back.sv =====
`default_nettype none
module ucrw_back #(
  parameter int NUM_CORES = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ucrw_pkg::entry_t  head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   ready,
  output logic                   done,
  output logic [31:0]            read_data,
  output logic [1:0]             status
);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_DATA, S_STS, S_PHY} state_t;

  state_t           state;
  logic [11:0]      cnt;
  logic [31:0]      mem [4096];
  logic [7:0]       phy [64];
  logic [31:0]      rd_q;
  logic [7:0]       phy_q;
  ucrw_pkg::entry_t cur;
  logic [31:0]      vhold;
  logic [31:0]      v;
  logic [31:0]      mask;
  logic [31:0]      rdv;
  logic [4:0]       shift;
  logic [11:0]      idx;
  logic             is_core;
  logic [31:0]      vcmd;
  logic [31:0]      snew;

  assign ready   = (state != S_INIT);
  assign pop     = (state == S_IDLE) && !empty;
  assign idx     = cur.addr[13:2];
  assign is_core = (cur.addr[13:11] == 3'd0);
  assign vcmd    = v & ~32'd2;

  always_comb begin
    shift = {cur.addr[1:0], 3'b000};
    mask  = ((cur.size == ucrw_pkg::SZ_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF) << shift;
    if (cur.size[1]) begin
      v = cur.data;
    end else begin
      v = (rd_q & ~mask) | ((cur.data << shift) & mask);
    end
    unique case (cur.size)
      ucrw_pkg::SZ_BYTE: rdv = (rd_q >> shift) & 32'h0000_00FF;
      ucrw_pkg::SZ_HALF: rdv = (rd_q >> {cur.addr[1], 4'b0000}) & 32'h0000_FFFF;
      default:           rdv = rd_q;
    endcase
    snew = rd_q;
    snew = vhold[5] ? (snew | ucrw_pkg::STS_ASS) : (snew & ~ucrw_pkg::STS_ASS);
    snew = vhold[4] ? (snew | ucrw_pkg::STS_PSS) : (snew & ~ucrw_pkg::STS_PSS);
    snew = vhold[0] ? (snew & ~ucrw_pkg::STS_HALT) : (snew | ucrw_pkg::STS_HALT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          mem[cnt] <= ucrw_pkg::reg_reset(cnt, NUM_CORES);
          if (cnt[11:6] == 6'd0) begin
            phy[cnt[5:0]] <= ucrw_pkg::phy_reset(cnt[5:0]);
          end
          cnt <= 12'(cnt + 12'd1);
          if (cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            cur  <= head;
            rd_q <= mem[head.addr[13:2]];
            if (head.err != ucrw_pkg::ST_OK) begin
              done      <= 1'b1;
              read_data <= '0;
              status    <= head.err;
            end else begin
              state <= S_DATA;
            end
          end
        end
        S_DATA: begin
          status    <= ucrw_pkg::ST_OK;
          read_data <= '0;
          vhold     <= v;
          state     <= S_IDLE;
          done      <= 1'b1;
          if (!cur.op) begin
            read_data <= rdv;
          end else if (is_core && idx[6:0] == ucrw_pkg::CW_CMD) begin
            mem[idx] <= vcmd;
            rd_q     <= mem[12'(idx + 12'd1)];
            done     <= 1'b0;
            state    <= S_STS;
          end else if (is_core && idx[6:0] == ucrw_pkg::CW_STS) begin
            mem[idx] <= (rd_q & ucrw_pkg::STS_RO) | (rd_q & ~ucrw_pkg::STS_RO & ~v);
          end else if (idx == {5'd0, ucrw_pkg::CW_VIEW}) begin
            if (v[31]) begin
              mem[idx] <= v & 32'h7FFF_FFFF;
            end else if (!v[30]) begin
              mem[idx] <= v;
            end else if (v[29]) begin
              phy[v[21:16]] <= v[7:0];
              mem[idx]      <= v & ~32'h4000_0000;
            end else begin
              phy_q <= phy[v[21:16]];
              done  <= 1'b0;
              state <= S_PHY;
            end
          end else begin
            mem[idx] <= v;
          end
        end
        S_STS: begin
          mem[12'(idx + 12'd1)] <= snew;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_PHY: begin
          mem[idx] <= (vhold & ~32'h4000_0000 & ~32'h0000_FF00) | {16'd0, phy_q, 8'd0};
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ucrw_pkg::ST_OK |-> read_data == 32'd0)
    else $error("error result with nonzero data");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !pop)
    else $error("pop while back end busy");
  a_no_done_init: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> !done)
    else $error("result during init sweep");
`endif

endmodule
`default_nettype wire

// ===== tb/usb_controller_register_window_test.sv =====
`default_nettype none
module usb_controller_register_window_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CORES = 4;
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_WIDE = 2'd3;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  st;
  } reply_t;

  typedef struct {
    logic        op;
    logic [13:0] addr;
    logic [1:0]  size;
    logic [31:0] wdata;
    logic        fixed;
    logic [31:0] exp_rdata;
    logic [1:0]  exp_st;
  } access_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        operation;
  logic [13:0] address;
  logic [1:0]  access_size;
  logic [31:0] write_data;
  logic        done;
  logic [31:0] read_data;
  logic [1:0]  status;

  logic [31:0] regs [0:4095];
  logic [7:0]  phy [0:63];
  reply_t      pending_replies [$];
  int          errors;
  logic        calm;

  usb_controller_register_window #(.NUM_CORES(NUM_CORES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .address(address), .access_size(access_size),
    .write_data(write_data), .done(done), .read_data(read_data), .status(status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic reg_decoded(input logic [13:0] off);
    logic [8:0] c;
    if (off >= 14'h800) return off <= 14'h83C && off[1:0] == 2'd0;
    if (off[10:9] >= NUM_CORES) return 1'b0;
    c = off[8:0];
    if (c[1:0] != 2'd0) return 1'b0;
    if (c >= 9'h140 && c <= 9'h164) return 1'b1;
    if (c >= 9'h1AC && c <= 9'h1DC) return 1'b1;
    return c == 9'h100 || c == 9'h104 || c == 9'h108 || c == 9'h120 ||
           c == 9'h124 || c == 9'h170 || c == 9'h180 || c == 9'h184 ||
           c == 9'h1A4 || c == 9'h1A8;
  endfunction

  function automatic logic [31:0] viewport_update(input logic [31:0] v);
    logic [5:0] r;
    if (v[31]) return {1'b0, v[30:0]};
    if (!v[30]) return v;
    r = v[21:16];
    if (v[29]) begin
      phy[r] = v[7:0];
      return v & ~32'h4000_0000;
    end
    return (v & ~32'h4000_FF00) | {16'd0, phy[r], 8'd0};
  endfunction

  function automatic void commit_word(input logic [13:0] off, input logic [31:0] v);
    logic [11:0] w;
    logic [31:0] s;
    w = off[13:2];
    if (off < 14'h800 && off[8:0] == 9'h140) begin
      v[1] = 1'b0;
      regs[w] = v;
      s = regs[w + 1];
      s = v[5] ? (s | ucrw_pkg::STS_ASS) : (s & ~ucrw_pkg::STS_ASS);
      s = v[4] ? (s | ucrw_pkg::STS_PSS) : (s & ~ucrw_pkg::STS_PSS);
      s = v[0] ? (s & ~ucrw_pkg::STS_HALT) : (s | ucrw_pkg::STS_HALT);
      regs[w + 1] = s;
    end else if (off < 14'h800 && off[8:0] == 9'h144) begin
      regs[w] = (regs[w] & ucrw_pkg::STS_RO) | (regs[w] & ~ucrw_pkg::STS_RO & ~v);
    end else if (off == 14'h170) begin
      regs[w] = viewport_update(v);
    end else begin
      regs[w] = v;
    end
  endfunction

  function automatic reply_t predict_access(input logic op, input logic [13:0] addr,
                                            input logic [1:0] size, input logic [31:0] d);
    reply_t res;
    logic [31:0] word;
    logic [31:0] mask;
    logic [4:0]  sh;
    res = '0;
    if (size >= SZ_WORD && addr[1:0] != 2'd0) begin
      res.st = ucrw_pkg::ST_UNALIGNED;
      return res;
    end
    if (!reg_decoded({addr[13:2], 2'b00})) begin
      res.st = ucrw_pkg::ST_UNMODELLED;
      return res;
    end
    word = regs[addr[13:2]];
    sh = {addr[1:0], 3'b000};
    if (op == OP_READ) begin
      if (size == ucrw_pkg::SZ_BYTE) res.rdata = (word >> sh) & 32'hFF;
      else if (size == ucrw_pkg::SZ_HALF) res.rdata = (word >> {addr[1], 4'b0000}) & 32'hFFFF;
      else res.rdata = word;
      return res;
    end
    if (size >= SZ_WORD) begin
      commit_word({addr[13:2], 2'b00}, d);
      return res;
    end
    mask = (size == ucrw_pkg::SZ_BYTE ? 32'hFF : 32'hFFFF) << sh;
    commit_word({addr[13:2], 2'b00}, (word & ~mask) | ((d << sh) & mask));
    return res;
  endfunction

  task automatic idle_burst();
    if (!calm && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
  endtask

  task automatic issue_access(input logic op, input logic [13:0] addr,
                              input logic [1:0] size, input logic [31:0] d,
                              input logic fixed, input logic [31:0] er,
                              input logic [1:0] es);
    reply_t p;
    operation <= op;
    address <= addr;
    access_size <= size;
    write_data <= d;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_access(op, addr, size, d);
    if (fixed) begin
      p.rdata = er;
      p.st = es;
    end
    pending_replies.push_back(p);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected transfer: read_data %h status %0d", read_data, status);
        errors++;
      end else begin
        e = pending_replies.pop_front();
        if (read_data !== e.rdata) begin
          $error("read_data: expected %h actual %h", e.rdata, read_data);
          errors++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d actual %0d", e.st, status);
          errors++;
        end
      end
    end
  end

  function automatic logic [13:0] pick_address();
    logic [13:0] a;
    int k;
    k = $urandom_range(9);
    a = {3'b000, 2'($urandom_range(3)), 9'd0};
    case (k)
      0: a = 14'($urandom_range(16383));
      1: a = 14'h800 + 14'($urandom_range(15) * 4);
      2: a = 14'h170;
      3: a = a + 14'h140;
      4: a = a + 14'h144;
      default: a = a + 14'h100 + 14'($urandom_range(63) * 4);
    endcase
    if ($urandom_range(4) == 0) a[1:0] = 2'($urandom_range(3));
    return a;
  endfunction

  function automatic logic [31:0] pick_data(input logic [13:0] a);
    logic [31:0] d;
    d = $urandom();
    if (a == 14'h170 && $urandom_range(2) != 0) begin
      d[31] = ($urandom_range(4) == 0);
      d[30] = 1'b1;
      d[21:16] = $urandom_range(4) == 0 ? 6'($urandom_range(63)) : 6'($urandom_range(3));
    end
    return d;
  endfunction

  access_row_t directed [] = '{
    '{OP_READ,  14'h0100, SZ_WORD, 32'h0, 1'b1, 32'h0100_0040, ucrw_pkg::ST_OK},
    '{OP_READ,  14'h0144, SZ_WORD, 32'h0, 1'b1, 32'h0000_1000, ucrw_pkg::ST_OK},
    '{OP_READ,  14'h0784, SZ_WORD, 32'h0, 1'b1, 32'h0000_1000, ucrw_pkg::ST_OK},
    '{OP_READ,  14'h0102, SZ_WORD, 32'h0, 1'b1, 32'h0, ucrw_pkg::ST_UNALIGNED},
    '{OP_WRITE, 14'h3FFF, SZ_WIDE, 32'hFFFF_FFFF, 1'b1, 32'h0, ucrw_pkg::ST_UNALIGNED},
    '{OP_READ,  14'h0000, SZ_WORD, 32'h0, 1'b1, 32'h0, ucrw_pkg::ST_UNMODELLED},
    '{OP_WRITE, 14'h3FFC, SZ_WORD, 32'hFFFF_FFFF, 1'b1, 32'h0, ucrw_pkg::ST_UNMODELLED},
    '{OP_READ,  14'h0840, ucrw_pkg::SZ_BYTE, 32'h0, 1'b1, 32'h0, ucrw_pkg::ST_UNMODELLED},
    '{OP_READ,  14'h0103, ucrw_pkg::SZ_BYTE, 32'h0, 1'b1, 32'h0000_0001, ucrw_pkg::ST_OK},
    '{OP_READ,  14'h0103, ucrw_pkg::SZ_HALF, 32'h0, 1'b1, 32'h0000_0100, ucrw_pkg::ST_OK},
    '{OP_WRITE, 14'h0140, SZ_WORD, 32'hFFFF_FFFF, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_READ,  14'h0144, SZ_WORD, 32'h0, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_WRITE, 14'h0144, SZ_WORD, 32'hFFFF_FFFF, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_WRITE, 14'h0170, SZ_WORD, 32'h6002_00AB, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_WRITE, 14'h0170, SZ_WORD, 32'h4002_0000, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_READ,  14'h0170, SZ_WORD, 32'h0, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_WRITE, 14'h0170, SZ_WORD, 32'hC000_0000, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_WRITE, 14'h0170, SZ_WORD, 32'h1234_5678, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_WRITE, 14'h0370, SZ_WORD, 32'h4001_0000, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_READ,  14'h0370, SZ_WORD, 32'h0, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_WRITE, 14'h0803, ucrw_pkg::SZ_HALF, 32'hFFFF_FFFF, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_READ,  14'h0800, SZ_WORD, 32'h0, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_WRITE, 14'h083D, ucrw_pkg::SZ_BYTE, 32'h0000_00FF, 1'b0, 32'h0, ucrw_pkg::ST_OK},
    '{OP_READ,  14'h083C, SZ_WORD, 32'h0, 1'b0, 32'h0, ucrw_pkg::ST_OK}
  };

  initial begin
    logic [13:0] a;
    logic [1:0]  sz;
    errors = 0;
    calm = 1'b0;
    start = 1'b0;
    operation = 1'b0;
    address = '0;
    access_size = '0;
    write_data = '0;
    for (int w = 0; w < 4096; w++) regs[w] = ucrw_pkg::reg_reset(12'(w), NUM_CORES);
    for (int p = 0; p < 64; p++) phy[p] = ucrw_pkg::phy_reset(6'(p));
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed[i]) begin
      issue_access(directed[i].op, directed[i].addr, directed[i].size, directed[i].wdata,
                   directed[i].fixed, directed[i].exp_rdata, directed[i].exp_st);
      idle_burst();
    end
    // hold the command side until the result side has drained
    start <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    for (int n = 0; n < 1200; n++) begin
      if (n >= 1000) calm = 1'b1;
      a = pick_address();
      sz = 2'($urandom_range(3));
      issue_access(1'($urandom_range(1)), a, sz, pick_data(a), 1'b0, '0, ucrw_pkg::ST_OK);
      idle_burst();
    end
    start <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) $display("** usb_controller_register_window: PASSED **");
    else $display("** usb_controller_register_window: FAILED **");
    $finish;
  end

  initial begin
    #2ms;
    $display("** usb_controller_register_window: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
